@@ rtl/core/fdmd_pkg.sv @@
// Shared types and constants of the frame difference motion detector.
package fdmd_pkg;

   localparam int FRAME_PIXELS = 76800;
   localparam int POS_W        = $clog2(FRAME_PIXELS + 1);
   localparam int ADDR_W       = $clog2(FRAME_PIXELS);
   localparam int CHAN_W       = 8;
   localparam int PIX_W        = 3 * CHAN_W;
   localparam int COUNT_W      = 17;
   localparam int PHASE_W      = 5;
   localparam int SLOT_W       = 4;
   localparam int THR_W        = 8;
   localparam int CSR_W        = 17;

   // Gray conversion: Y = (1868*B + 9617*G + 4899*R + 8192) >> 14.
   localparam int PROD_W       = 23;
   localparam int GRAY_SHIFT   = 14;
   localparam int GRAY_W       = PROD_W - GRAY_SHIFT;
   localparam int COEF_B       = 1868;
   localparam int COEF_G       = 9617;
   localparam int COEF_R       = 4899;
   localparam int GRAY_ROUND   = 8192;

   localparam logic [SLOT_W-1:0]  RESET_REFERENCE_SLOT  = 4'd5;
   localparam logic [SLOT_W-1:0]  RESET_COMPARE_GAP     = 4'd4;
   localparam logic [THR_W-1:0]   RESET_PIXEL_THRESHOLD = 8'd30;
   localparam logic [COUNT_W-1:0] RESET_COUNT_THRESHOLD = 17'd1000;

   typedef enum logic [1:0] {
      CSR_REFERENCE_SLOT,
      CSR_COMPARE_GAP,
      CSR_PIXEL_THRESHOLD,
      CSR_COUNT_THRESHOLD
   } csr_index_type;

   typedef struct packed {
      logic              wr_en;
      logic              rd_en;
      logic [ADDR_W-1:0] addr;
      logic [PIX_W-1:0]  wr_data;
   } fdmd_ram_req_type;

   typedef struct packed {
      logic valid;
      logic compare;
      logic last;
      logic emit;
   } fdmd_tag_type;

   typedef struct packed {
      logic               valid;
      logic [COUNT_W-1:0] count;
      logic               motion;
   } fdmd_result_type;

endpackage

@@ rtl/core/fdmd_ref_ram.sv @@
// Single-port reference frame memory with a registered read.
module fdmd_ref_ram #(
   parameter int DEPTH = 76800,
   parameter int WIDTH = 24
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [0:DEPTH-1];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/core/fdmd_frame_seq.sv @@
// Frame sequencer: pixel position, frame phase and reference memory access.
module fdmd_frame_seq import fdmd_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                advance,
   input  logic                req_valid,
   input  logic [CHAN_W-1:0]   req_blue,
   input  logic [CHAN_W-1:0]   req_green,
   input  logic [CHAN_W-1:0]   req_red,
   input  logic                req_frame_end,
   input  logic [SLOT_W-1:0]   reference_slot,
   input  logic [SLOT_W-1:0]   compare_gap,
   output fdmd_ram_req_type    ram_req,
   output fdmd_tag_type        tag,
   output logic [PIX_W-1:0]    pixel
);

   logic [POS_W-1:0]   pos_ff, pos_in;
   logic [PHASE_W-1:0] phase_ff, phase_in;
   fdmd_tag_type       tag_ff, tag_in;
   logic [PIX_W-1:0]   pixel_ff;

   logic               accept;
   logic [SLOT_W-1:0]  ref_num;
   logic [SLOT_W-1:0]  gap_num;
   logic [PHASE_W-1:0] cmp_num;
   logic [PHASE_W:0]   number;
   logic               is_ref;
   logic               is_cmp;
   logic               in_range;
   logic [PIX_W-1:0]   pixel_word;

   assign accept     = req_valid && advance;
   // A zero slot or gap behaves as one.
   assign ref_num    = (reference_slot == '0) ? SLOT_W'(1) : reference_slot;
   assign gap_num    = (compare_gap == '0) ? SLOT_W'(1) : compare_gap;
   assign cmp_num    = PHASE_W'(ref_num) + PHASE_W'(gap_num);
   assign number     = {1'b0, phase_ff} + (PHASE_W+1)'(1);
   assign is_ref     = number == (PHASE_W+1)'(ref_num);
   assign is_cmp     = number == (PHASE_W+1)'(cmp_num);
   assign in_range   = pos_ff < POS_W'(FRAME_PIXELS);
   assign pixel_word = {req_red, req_green, req_blue};

   always_comb begin
      ram_req.wr_en   = accept && in_range && is_ref;
      ram_req.rd_en   = accept && in_range && is_cmp;
      ram_req.addr    = pos_ff[ADDR_W-1:0];
      ram_req.wr_data = pixel_word;

      pos_in   = pos_ff;
      phase_in = phase_ff;
      if (accept) begin
         if (req_frame_end) begin
            pos_in = '0;
            // Past the compare frame the cycle restarts as well.
            if (number >= (PHASE_W+1)'(cmp_num)) begin
               phase_in = '0;
            end else begin
               phase_in = number[PHASE_W-1:0];
            end
         end else if (in_range) begin
            pos_in = pos_ff + POS_W'(1);
         end
      end

      tag_in.valid   = accept;
      tag_in.compare = is_cmp && in_range;
      tag_in.last    = req_frame_end;
      tag_in.emit    = req_frame_end && is_cmp;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         phase_ff     <= '0;
         tag_ff.valid <= 1'b0;
      end else begin
         pos_ff   <= pos_in;
         phase_ff <= phase_in;
         if (advance) begin
            tag_ff.valid <= tag_in.valid;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         tag_ff.compare <= tag_in.compare;
         tag_ff.last    <= tag_in.last;
         tag_ff.emit    <= tag_in.emit;
         pixel_ff       <= pixel_word;
      end
   end

   assign tag   = tag_ff;
   assign pixel = pixel_ff;

endmodule

@@ rtl/core/fdmd_diff_tally.sv @@
// Difference, gray conversion, threshold test and changed pixel tally.
module fdmd_diff_tally import fdmd_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               advance,
   input  fdmd_tag_type       tag,
   input  logic [PIX_W-1:0]   pixel,
   input  logic [PIX_W-1:0]   ref_pixel,
   input  logic [THR_W-1:0]   pixel_threshold,
   input  logic [COUNT_W-1:0] count_threshold,
   output logic               result_pending,
   output fdmd_result_type    result
);

   fdmd_tag_type       c_tag_ff;
   logic [PROD_W-1:0]  prod_b_ff, prod_g_ff, prod_r_ff;
   logic [COUNT_W-1:0] tally_ff, tally_in;

   logic [CHAN_W-1:0]  diff_b, diff_g, diff_r;
   logic [PROD_W-1:0]  gray_sum;
   logic [GRAY_W-1:0]  gray;
   logic               changed;
   logic [COUNT_W-1:0] tally_next;
   logic               consume;

   function automatic logic [CHAN_W-1:0] abs_diff(input logic [CHAN_W-1:0] a,
                                                   input logic [CHAN_W-1:0] b);
      return (a > b) ? a - b : b - a;
   endfunction

   assign diff_b = abs_diff(pixel[CHAN_W-1:0], ref_pixel[CHAN_W-1:0]);
   assign diff_g = abs_diff(pixel[2*CHAN_W-1:CHAN_W], ref_pixel[2*CHAN_W-1:CHAN_W]);
   assign diff_r = abs_diff(pixel[3*CHAN_W-1:2*CHAN_W], ref_pixel[3*CHAN_W-1:2*CHAN_W]);

   always_ff @(posedge clock) begin
      if (reset) begin
         c_tag_ff.valid <= 1'b0;
      end else if (advance) begin
         c_tag_ff.valid <= tag.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         c_tag_ff.compare <= tag.compare;
         c_tag_ff.last    <= tag.last;
         c_tag_ff.emit    <= tag.emit;
         prod_b_ff        <= PROD_W'(diff_b) * PROD_W'(COEF_B);
         prod_g_ff        <= PROD_W'(diff_g) * PROD_W'(COEF_G);
         prod_r_ff        <= PROD_W'(diff_r) * PROD_W'(COEF_R);
      end
   end

   assign consume  = c_tag_ff.valid && advance;
   assign gray_sum = prod_b_ff + prod_g_ff + prod_r_ff + PROD_W'(GRAY_ROUND);
   assign gray     = gray_sum[PROD_W-1:GRAY_SHIFT];
   assign changed  = c_tag_ff.compare && (gray > GRAY_W'(pixel_threshold));

   always_comb begin
      tally_next = tally_ff;
      if (changed && (tally_ff < COUNT_W'(FRAME_PIXELS))) begin
         tally_next = tally_ff + COUNT_W'(1);
      end
      tally_in = tally_ff;
      if (consume) begin
         tally_in = c_tag_ff.last ? '0 : tally_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tally_ff <= '0;
      end else begin
         tally_ff <= tally_in;
      end
   end

   assign result_pending = c_tag_ff.valid && c_tag_ff.emit;
   assign result.valid   = consume && c_tag_ff.emit;
   assign result.count   = tally_next;
   assign result.motion  = tally_next >= count_threshold;

endmodule

@@ rtl/core/frame_difference_motion_detector.sv @@
// Top level of the frame difference motion detector.
// Throughput: one pixel per cycle; the input stalls only while a result waits
// in the output register and the next compare-frame result reaches the tally.
// The last pixel of the compare frame passes the memory read, the product
// stage, the tally and the output register before its result is valid.
// Reset clears position, phase, tally, pipeline valids and the control registers to
// their defaults; the reference memory is not cleared and needs no sweep.
module frame_difference_motion_detector import fdmd_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [CHAN_W-1:0]  req_blue,
   input  logic [CHAN_W-1:0]  req_green,
   input  logic [CHAN_W-1:0]  req_red,
   input  logic               req_frame_end,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [COUNT_W-1:0] rsp_changed_pixels,
   output logic               rsp_motion_found,
   input  logic               csr_write_enable,
   input  logic [1:0]         csr_index,
   input  logic [CSR_W-1:0]   csr_data
);

   logic [SLOT_W-1:0]  reference_slot_ff;
   logic [SLOT_W-1:0]  compare_gap_ff;
   logic [THR_W-1:0]   pixel_threshold_ff;
   logic [COUNT_W-1:0] count_threshold_ff;

   logic               rsp_valid_ff;
   logic [COUNT_W-1:0] rsp_count_ff;
   logic               rsp_motion_ff;

   fdmd_ram_req_type   ram_req;
   fdmd_tag_type       b_tag;
   logic [PIX_W-1:0]   b_pixel;
   logic [PIX_W-1:0]   ref_pixel;
   logic               result_pending;
   fdmd_result_type    result;
   logic               advance;

   // The whole pipeline holds only when a new result would overwrite one
   // that has not been taken.
   assign advance   = !(result_pending && rsp_valid_ff && !rsp_ready);
   assign req_ready = advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         reference_slot_ff  <= RESET_REFERENCE_SLOT;
         compare_gap_ff     <= RESET_COMPARE_GAP;
         pixel_threshold_ff <= RESET_PIXEL_THRESHOLD;
         count_threshold_ff <= RESET_COUNT_THRESHOLD;
      end else if (csr_write_enable) begin
         unique case (csr_index_type'(csr_index))
            CSR_REFERENCE_SLOT: begin
               reference_slot_ff <= csr_data[SLOT_W-1:0];
            end
            CSR_COMPARE_GAP: begin
               compare_gap_ff <= csr_data[SLOT_W-1:0];
            end
            CSR_PIXEL_THRESHOLD: begin
               pixel_threshold_ff <= csr_data[THR_W-1:0];
            end
            CSR_COUNT_THRESHOLD: begin
               count_threshold_ff <= csr_data[COUNT_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   fdmd_frame_seq u_seq (
      .clock          (clock),
      .reset          (reset),
      .advance        (advance),
      .req_valid      (req_valid),
      .req_blue       (req_blue),
      .req_green      (req_green),
      .req_red        (req_red),
      .req_frame_end  (req_frame_end),
      .reference_slot (reference_slot_ff),
      .compare_gap    (compare_gap_ff),
      .ram_req        (ram_req),
      .tag            (b_tag),
      .pixel          (b_pixel)
   );

   fdmd_ref_ram #(
      .DEPTH (FRAME_PIXELS),
      .WIDTH (PIX_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_req.wr_en),
      .rd_en   (ram_req.rd_en),
      .addr    (ram_req.addr),
      .wr_data (ram_req.wr_data),
      .rd_data (ref_pixel)
   );

   fdmd_diff_tally u_diff (
      .clock           (clock),
      .reset           (reset),
      .advance         (advance),
      .tag             (b_tag),
      .pixel           (b_pixel),
      .ref_pixel       (ref_pixel),
      .pixel_threshold (pixel_threshold_ff),
      .count_threshold (count_threshold_ff),
      .result_pending  (result_pending),
      .result          (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (result.valid) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (result.valid) begin
         rsp_count_ff  <= result.count;
         rsp_motion_ff <= result.motion;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_changed_pixels = rsp_count_ff;
   assign rsp_motion_found   = rsp_motion_ff;

   // A reference frame pixel is never stored and compared in the same cycle.
   assert property (@(posedge clock) disable iff (reset)
      !(ram_req.wr_en && ram_req.rd_en))
      else $error("reference memory written and read in one cycle");

   // A waiting result is never overwritten by the next one.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |-> !result.valid)
      else $error("pending transaction overwritten");

   // The reported count stays within the frame size.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_count_ff <= COUNT_W'(FRAME_PIXELS)))
      else $error("changed pixel count above frame size");

   // Memory accesses only happen for accepted transactions.
   assert property (@(posedge clock) disable iff (reset)
      (ram_req.wr_en || ram_req.rd_en) |-> (req_valid && req_ready))
      else $error("memory access without an accepted transaction");

endmodule
